/* hdl/wia_pkg.sv */
// wia_pkg: request/response types, opcodes, status codes and bit-count helpers
// for the integer alu pipeline; no dependencies
`default_nettype none

package wia_pkg;

   localparam int DIV_STEPS = 64;

   typedef struct packed {
      logic [7:0]  cmd;
      logic [63:0] operand_a;
      logic [63:0] operand_b;
      logic [63:0] operand_c;
      logic [63:0] immediate;
   } req_type;

   typedef struct packed {
      logic [63:0] result;
      logic [2:0]  status;
   } rsp_type;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INVALID  = 3'd1;
   localparam logic [2:0] ST_CALLTYPE = 3'd2;
   localparam logic [2:0] ST_DIVZERO  = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   // result source at the last stage
   localparam logic [1:0] KIND_SIMPLE = 2'd0;
   localparam logic [1:0] KIND_MUL    = 2'd1;
   localparam logic [1:0] KIND_DIV    = 2'd2;

   localparam logic [7:0] OP_PASS     = 8'h00;
   localparam logic [7:0] OP_BAD1     = 8'h01;
   localparam logic [7:0] OP_MIN      = 8'h02;
   localparam logic [7:0] OP_SELECT   = 8'h03;
   localparam logic [7:0] OP_BRTABLE  = 8'h04;
   localparam logic [7:0] OP_BAD6     = 8'h06;
   localparam logic [7:0] OP_CALLCHK  = 8'h07;
   localparam logic [7:0] OP_I32_EQZ  = 8'h45;
   localparam logic [7:0] OP_I32_EQ   = 8'h46;
   localparam logic [7:0] OP_I32_NE   = 8'h47;
   localparam logic [7:0] OP_I32_LT_S = 8'h48;
   localparam logic [7:0] OP_I32_LT_U = 8'h49;
   localparam logic [7:0] OP_I32_GT_S = 8'h4a;
   localparam logic [7:0] OP_I32_GT_U = 8'h4b;
   localparam logic [7:0] OP_I32_LE_S = 8'h4c;
   localparam logic [7:0] OP_I32_LE_U = 8'h4d;
   localparam logic [7:0] OP_I32_GE_S = 8'h4e;
   localparam logic [7:0] OP_I32_GE_U = 8'h4f;
   localparam logic [7:0] OP_I64_EQZ  = 8'h50;
   localparam logic [7:0] OP_I64_EQ   = 8'h51;
   localparam logic [7:0] OP_I64_NE   = 8'h52;
   localparam logic [7:0] OP_I64_LT_S = 8'h53;
   localparam logic [7:0] OP_I64_LT_U = 8'h54;
   localparam logic [7:0] OP_I64_GT_S = 8'h55;
   localparam logic [7:0] OP_I64_GT_U = 8'h56;
   localparam logic [7:0] OP_I64_LE_S = 8'h57;
   localparam logic [7:0] OP_I64_LE_U = 8'h58;
   localparam logic [7:0] OP_I64_GE_S = 8'h59;
   localparam logic [7:0] OP_I64_GE_U = 8'h5a;
   localparam logic [7:0] OP_I32_CLZ  = 8'h67;
   localparam logic [7:0] OP_I32_CTZ  = 8'h68;
   localparam logic [7:0] OP_I32_POP  = 8'h69;
   localparam logic [7:0] OP_I32_ADD  = 8'h6a;
   localparam logic [7:0] OP_I32_SUB  = 8'h6b;
   localparam logic [7:0] OP_I32_MUL  = 8'h6c;
   localparam logic [7:0] OP_I32_DIVS = 8'h6d;
   localparam logic [7:0] OP_I32_DIVU = 8'h6e;
   localparam logic [7:0] OP_I32_REMS = 8'h6f;
   localparam logic [7:0] OP_I32_REMU = 8'h70;
   localparam logic [7:0] OP_I32_AND  = 8'h71;
   localparam logic [7:0] OP_I32_OR   = 8'h72;
   localparam logic [7:0] OP_I32_XOR  = 8'h73;
   localparam logic [7:0] OP_I32_SHL  = 8'h74;
   localparam logic [7:0] OP_I32_SHRS = 8'h75;
   localparam logic [7:0] OP_I32_SHRU = 8'h76;
   localparam logic [7:0] OP_I32_ROTL = 8'h77;
   localparam logic [7:0] OP_I32_ROTR = 8'h78;
   localparam logic [7:0] OP_I64_CLZ  = 8'h79;
   localparam logic [7:0] OP_I64_CTZ  = 8'h7a;
   localparam logic [7:0] OP_I64_POP  = 8'h7b;
   localparam logic [7:0] OP_I64_ADD  = 8'h7c;
   localparam logic [7:0] OP_I64_SUB  = 8'h7d;
   localparam logic [7:0] OP_I64_MUL  = 8'h7e;
   localparam logic [7:0] OP_I64_DIVS = 8'h7f;
   localparam logic [7:0] OP_I64_DIVU = 8'h80;
   localparam logic [7:0] OP_I64_REMS = 8'h81;
   localparam logic [7:0] OP_I64_REMU = 8'h82;
   localparam logic [7:0] OP_I64_AND  = 8'h83;
   localparam logic [7:0] OP_I64_OR   = 8'h84;
   localparam logic [7:0] OP_I64_XOR  = 8'h85;
   localparam logic [7:0] OP_I64_SHL  = 8'h86;
   localparam logic [7:0] OP_I64_SHRS = 8'h87;
   localparam logic [7:0] OP_I64_SHRU = 8'h88;
   localparam logic [7:0] OP_I64_ROTL = 8'h89;
   localparam logic [7:0] OP_I64_ROTR = 8'h8a;

   localparam logic [1:0] EXTRACT_TAG = 2'b11;

   // one pipeline slot: divider state plus everything the last stage needs
   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] quo;
      logic [63:0] divisor;
      logic [63:0] result;
      logic [2:0]  status;
      logic [1:0]  kind;
      logic        is32;
      logic        want_rem;
      logic        neg_q;
      logic        neg_r;
      logic [63:0] pp0;
      logic [31:0] pp1;
      logic [31:0] pp2;
   } pipe_type;

   function automatic logic [6:0] clz64(input logic [63:0] x);
      logic [6:0] n;
      n = 7'd64;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) n = 7'(63 - i);
      end
      return n;
   endfunction

   function automatic logic [6:0] ctz64(input logic [63:0] x);
      logic [6:0] n;
      n = 7'd64;
      for (int i = 63; i >= 0; i--) begin
         if (x[i]) n = 7'(i);
      end
      return n;
   endfunction

   function automatic logic [6:0] pop64(input logic [63:0] x);
      logic [6:0] n;
      n = 7'd0;
      for (int i = 0; i < 64; i++) begin
         n = n + 7'(x[i]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

/* hdl/wia_front.sv */
// wia_front: decode stage; computes simple results, multiply partial
// products and divider operands. uses wia_pkg
`default_nettype none

module wia_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              in_valid,
   input  wire wia_pkg::req_type  in_item,
   output logic                   out_valid,
   output wia_pkg::pipe_type      out_stage
);

   logic              valid_ff;
   wia_pkg::pipe_type stage_ff;
   wia_pkg::pipe_type stage_in;

   logic [7:0]  cmd;
   logic [63:0] a, b, c, imm;
   logic [31:0] a32, b32;
   logic        div_op, div_signed, div_is32, div_rem;
   logic [63:0] x, y, ux, uy;
   logic        nx, ny;
   logic [63:0] min_ab;
   logic [127:0] rot64;
   logic [63:0]  rot32;
   logic [4:0]   s32;
   logic [5:0]   s64;
   // byte extract
   logic [1:0]   ex_ty;
   logic [2:0]   ex_pk;
   logic [2:0]   ex_off;
   logic [3:0]   ex_n;
   logic         ex_bad;
   logic [127:0] ex_win;
   logic [63:0]  ex_val;
   logic [5:0]   ex_sidx;
   logic         ex_sign;

   assign cmd = in_item.cmd;
   assign a   = in_item.operand_a;
   assign b   = in_item.operand_b;
   assign c   = in_item.operand_c;
   assign imm = in_item.immediate;
   assign a32 = a[31:0];
   assign b32 = b[31:0];
   assign s32 = b[4:0];
   assign s64 = b[5:0];
   assign min_ab = (a < b) ? a : b;

   always_comb begin
      div_op     = 1'b0;
      div_signed = 1'b0;
      div_is32   = 1'b0;
      div_rem    = 1'b0;
      case (cmd)
         wia_pkg::OP_I32_DIVS: begin div_op = 1'b1; div_signed = 1'b1; div_is32 = 1'b1; end
         wia_pkg::OP_I32_REMS: begin
            div_op = 1'b1; div_signed = 1'b1; div_is32 = 1'b1; div_rem = 1'b1;
         end
         wia_pkg::OP_I32_DIVU: begin div_op = 1'b1; div_is32 = 1'b1; end
         wia_pkg::OP_I32_REMU: begin div_op = 1'b1; div_is32 = 1'b1; div_rem = 1'b1; end
         wia_pkg::OP_I64_DIVS: begin div_op = 1'b1; div_signed = 1'b1; end
         wia_pkg::OP_I64_REMS: begin div_op = 1'b1; div_signed = 1'b1; div_rem = 1'b1; end
         wia_pkg::OP_I64_DIVU: div_op = 1'b1;
         wia_pkg::OP_I64_REMU: begin div_op = 1'b1; div_rem = 1'b1; end
         default: div_op = 1'b0;
      endcase
   end

   always_comb begin
      if (div_is32) begin
         x = div_signed ? {{32{a32[31]}}, a32} : {32'd0, a32};
         y = div_signed ? {{32{b32[31]}}, b32} : {32'd0, b32};
      end else begin
         x = a;
         y = b;
      end
      nx = div_signed & x[63];
      ny = div_signed & y[63];
      ux = nx ? (64'd0 - x) : x;
      uy = ny ? (64'd0 - y) : y;
   end

   always_comb begin
      ex_ty   = cmd[5:4];
      ex_pk   = cmd[3:1];
      ex_off  = a[2:0] + imm[2:0];
      ex_win  = {c, b} >> {ex_off, 3'b000};
      ex_bad  = (ex_pk != 3'd0) && (ex_ty[1] || (ex_ty == 2'd0 && ex_pk == 3'd4));
      if (ex_pk == 3'd0) ex_n = (ex_ty[0] == 1'b0) ? 4'd4 : 4'd8;
      else               ex_n = {1'b0, ex_pk};
      ex_sidx = {ex_pk, 3'b000} - 6'd1;
      ex_sign = (ex_pk != 3'd0) && cmd[0] && ex_win[ex_sidx];
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < ex_n)  ex_val[8*i +: 8] = ex_win[8*i +: 8];
         else if (ex_sign)  ex_val[8*i +: 8] = 8'hff;
         else               ex_val[8*i +: 8] = 8'h00;
      end
      if (ex_pk != 3'd0 && ex_ty == 2'd0) ex_val[63:32] = 32'd0;
   end

   assign rot32 = {a32, a32} << s32;
   assign rot64 = {a, a} << s64;

   always_comb begin
      stage_in          = '0;
      stage_in.rem      = 64'd0;
      stage_in.quo      = ux;
      stage_in.divisor  = uy;
      stage_in.result   = a;
      stage_in.status   = wia_pkg::ST_OK;
      stage_in.kind     = wia_pkg::KIND_SIMPLE;
      stage_in.is32     = div_is32;
      stage_in.want_rem = div_rem;
      stage_in.neg_q    = nx ^ ny;
      stage_in.neg_r    = nx;
      stage_in.pp0      = {32'd0, a32} * {32'd0, b32};
      stage_in.pp1      = 32'(a32 * b[63:32]);
      stage_in.pp2      = 32'(a[63:32] * b32);

      if (div_op) begin
         if (y == 64'd0) begin
            stage_in.result = 64'd0;
            stage_in.status = wia_pkg::ST_DIVZERO;
         end else if (div_signed && y == '1 &&
                      x == (div_is32 ? 64'hffff_ffff_8000_0000 : 64'h8000_0000_0000_0000)) begin
            stage_in.result = 64'd0;
            stage_in.status = div_rem ? wia_pkg::ST_OK : wia_pkg::ST_OVERFLOW;
         end else begin
            stage_in.kind = wia_pkg::KIND_DIV;
         end
      end

      case (cmd)
         wia_pkg::OP_PASS:    stage_in.result = a;
         wia_pkg::OP_BAD1,
         wia_pkg::OP_BAD6: begin
            stage_in.result = 64'd0;
            stage_in.status = wia_pkg::ST_INVALID;
         end
         wia_pkg::OP_MIN:     stage_in.result = min_ab;
         wia_pkg::OP_SELECT:  stage_in.result = (b != 64'd0) ? a : c;
         wia_pkg::OP_BRTABLE: stage_in.result = b + ((a >= imm) ? imm : a);
         wia_pkg::OP_CALLCHK: begin
            stage_in.result = 64'd0;
            if (imm != b) stage_in.status = wia_pkg::ST_CALLTYPE;
         end
         wia_pkg::OP_I32_EQZ:  stage_in.result = {63'd0, a32 == 32'd0};
         wia_pkg::OP_I32_EQ:   stage_in.result = {63'd0, a32 == b32};
         wia_pkg::OP_I32_NE:   stage_in.result = {63'd0, a32 != b32};
         wia_pkg::OP_I32_LT_S: stage_in.result = {63'd0, $signed(a32) < $signed(b32)};
         wia_pkg::OP_I32_LT_U: stage_in.result = {63'd0, a32 < b32};
         wia_pkg::OP_I32_GT_S: stage_in.result = {63'd0, $signed(a32) > $signed(b32)};
         wia_pkg::OP_I32_GT_U: stage_in.result = {63'd0, a32 > b32};
         wia_pkg::OP_I32_LE_S: stage_in.result = {63'd0, $signed(a32) <= $signed(b32)};
         wia_pkg::OP_I32_LE_U: stage_in.result = {63'd0, a32 <= b32};
         wia_pkg::OP_I32_GE_S: stage_in.result = {63'd0, $signed(a32) >= $signed(b32)};
         wia_pkg::OP_I32_GE_U: stage_in.result = {63'd0, a32 >= b32};
         wia_pkg::OP_I64_EQZ:  stage_in.result = {63'd0, a == 64'd0};
         wia_pkg::OP_I64_EQ:   stage_in.result = {63'd0, a == b};
         wia_pkg::OP_I64_NE:   stage_in.result = {63'd0, a != b};
         wia_pkg::OP_I64_LT_S: stage_in.result = {63'd0, $signed(a) < $signed(b)};
         wia_pkg::OP_I64_LT_U: stage_in.result = {63'd0, a < b};
         wia_pkg::OP_I64_GT_S: stage_in.result = {63'd0, $signed(a) > $signed(b)};
         wia_pkg::OP_I64_GT_U: stage_in.result = {63'd0, a > b};
         wia_pkg::OP_I64_LE_S: stage_in.result = {63'd0, $signed(a) <= $signed(b)};
         wia_pkg::OP_I64_LE_U: stage_in.result = {63'd0, a <= b};
         wia_pkg::OP_I64_GE_S: stage_in.result = {63'd0, $signed(a) >= $signed(b)};
         wia_pkg::OP_I64_GE_U: stage_in.result = {63'd0, a >= b};
         // padding with ones caps the 32-bit zero counts at 32
         wia_pkg::OP_I32_CLZ:
            stage_in.result = {57'd0, wia_pkg::clz64({a32, 32'hffff_ffff})};
         wia_pkg::OP_I32_CTZ:
            stage_in.result = {57'd0, wia_pkg::ctz64({32'hffff_ffff, a32})};
         wia_pkg::OP_I32_POP:  stage_in.result = {57'd0, wia_pkg::pop64({32'd0, a32})};
         wia_pkg::OP_I32_ADD:  stage_in.result = {32'd0, a32 + b32};
         wia_pkg::OP_I32_SUB:  stage_in.result = {32'd0, a32 - b32};
         wia_pkg::OP_I32_MUL: begin
            stage_in.kind = wia_pkg::KIND_MUL;
            stage_in.is32 = 1'b1;
         end
         wia_pkg::OP_I32_AND:  stage_in.result = {32'd0, a32 & b32};
         wia_pkg::OP_I32_OR:   stage_in.result = {32'd0, a32 | b32};
         wia_pkg::OP_I32_XOR:  stage_in.result = {32'd0, a32 ^ b32};
         wia_pkg::OP_I32_SHL:  stage_in.result = {32'd0, a32 << s32};
         wia_pkg::OP_I32_SHRS: stage_in.result = {32'd0, 32'($signed(a32) >>> s32)};
         wia_pkg::OP_I32_SHRU: stage_in.result = {32'd0, a32 >> s32};
         wia_pkg::OP_I32_ROTL: stage_in.result = {32'd0, rot32[63:32]};
         wia_pkg::OP_I32_ROTR: stage_in.result = {32'd0, 32'({a32, a32} >> s32)};
         wia_pkg::OP_I64_CLZ:  stage_in.result = {57'd0, wia_pkg::clz64(a)};
         wia_pkg::OP_I64_CTZ:  stage_in.result = {57'd0, wia_pkg::ctz64(a)};
         wia_pkg::OP_I64_POP:  stage_in.result = {57'd0, wia_pkg::pop64(a)};
         wia_pkg::OP_I64_ADD:  stage_in.result = a + b;
         wia_pkg::OP_I64_SUB:  stage_in.result = a - b;
         wia_pkg::OP_I64_MUL: begin
            stage_in.kind = wia_pkg::KIND_MUL;
            stage_in.is32 = 1'b0;
         end
         wia_pkg::OP_I64_AND:  stage_in.result = a & b;
         wia_pkg::OP_I64_OR:   stage_in.result = a | b;
         wia_pkg::OP_I64_XOR:  stage_in.result = a ^ b;
         wia_pkg::OP_I64_SHL:  stage_in.result = a << s64;
         wia_pkg::OP_I64_SHRS: stage_in.result = 64'($signed(a) >>> s64);
         wia_pkg::OP_I64_SHRU: stage_in.result = a >> s64;
         wia_pkg::OP_I64_ROTL: stage_in.result = rot64[127:64];
         wia_pkg::OP_I64_ROTR: stage_in.result = 64'({a, a} >> s64);
         default: begin
            if (cmd[7:6] == wia_pkg::EXTRACT_TAG) begin
               stage_in.result = ex_bad ? 64'd0 : ex_val;
               stage_in.status = ex_bad ? wia_pkg::ST_INVALID : wia_pkg::ST_OK;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

`default_nettype wire

/* hdl/wia_div_step.sv */
// wia_div_step: one restoring-division stage, one quotient bit per stage;
// carries the rest of the pipeline slot along. uses wia_pkg
`default_nettype none

module wia_div_step (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_valid,
   input  wire wia_pkg::pipe_type  in_stage,
   output logic                    out_valid,
   output wia_pkg::pipe_type       out_stage
);

   logic              valid_ff;
   wia_pkg::pipe_type stage_ff;
   wia_pkg::pipe_type stage_in;
   logic [64:0]       shifted;
   logic [64:0]       diff;
   logic              fits;

   assign shifted = {in_stage.rem, in_stage.quo[63]};
   assign diff    = shifted - {1'b0, in_stage.divisor};
   assign fits    = ~diff[64];

   always_comb begin
      stage_in     = in_stage;
      stage_in.rem = fits ? diff[63:0] : shifted[63:0];
      stage_in.quo = {in_stage.quo[62:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

`default_nettype wire

/* hdl/wia_back.sv */
// wia_back: final stage; sign-corrects quotient and remainder, sums the
// multiply partial products and holds the response. uses wia_pkg
`default_nettype none

module wia_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_valid,
   input  wire wia_pkg::pipe_type  in_stage,
   output logic                    out_valid,
   output wia_pkg::rsp_type        out_item
);

   logic             valid_ff;
   wia_pkg::rsp_type item_ff;
   wia_pkg::rsp_type item_in;
   logic [63:0]      quo_fix, rem_fix, div_val, mul_val;

   assign quo_fix = in_stage.neg_q ? (64'd0 - in_stage.quo) : in_stage.quo;
   assign rem_fix = in_stage.neg_r ? (64'd0 - in_stage.rem) : in_stage.rem;
   assign div_val = in_stage.want_rem ? rem_fix : quo_fix;
   assign mul_val = in_stage.pp0 + {in_stage.pp1 + in_stage.pp2, 32'd0};

   always_comb begin
      item_in.status = in_stage.status;
      case (in_stage.kind)
         wia_pkg::KIND_MUL:
            item_in.result = in_stage.is32 ? {32'd0, in_stage.pp0[31:0]} : mul_val;
         wia_pkg::KIND_DIV:
            item_in.result = in_stage.is32 ? {32'd0, div_val[31:0]} : div_val;
         default:
            item_in.result = in_stage.result;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

/* hdl/wasm_integer_alu.sv */
// wasm_integer_alu: top level; decode stage, divider stages and result stage
// built from wia_front, wia_div_step and wia_back, types from wia_pkg
`default_nettype none

// 64-bit integer alu with webassembly opcode numbering. One request is taken
// every cycle while req_stall is low, and every request, whatever its opcode,
// passes 66 register stages (one decode stage, 64 divider stages, one result
// stage), so responses come out in request order. The depth is set by the
// divider, which resolves one quotient bit per stage. When the response is
// stalled the whole pipeline holds and req_stall is raised; nothing needs
// clearing after reset.
module wasm_integer_alu (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire wia_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output wia_pkg::rsp_type       rsp_data
);

   logic              advance;
   logic              pipe_valid [wia_pkg::DIV_STEPS+1];
   wia_pkg::pipe_type pipe_stage [wia_pkg::DIV_STEPS+1];

   assign advance   = ~(rsp_valid & rsp_stall);
   assign req_stall = ~advance;

   wia_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_item   (req_data),
      .out_valid (pipe_valid[0]),
      .out_stage (pipe_stage[0])
   );

   for (genvar g = 0; g < wia_pkg::DIV_STEPS; g++) begin : g_div
      wia_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (pipe_valid[g]),
         .in_stage  (pipe_stage[g]),
         .out_valid (pipe_valid[g+1]),
         .out_stage (pipe_stage[g+1])
      );
   end

   wia_back u_back (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (pipe_valid[wia_pkg::DIV_STEPS]),
      .in_stage  (pipe_stage[wia_pkg::DIV_STEPS]),
      .out_valid (rsp_valid),
      .out_item  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= wia_pkg::ST_OVERFLOW)
      else $error("status code out of range");

   a_trap_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != wia_pkg::ST_OK) |-> rsp_data.result == 64'd0)
      else $error("trapped response carries a nonzero result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule

`default_nettype wire
